### design/sch_pkg.sv
// ============================================================================
// sch_pkg: shared widths and types for the sphere/capsule hit test
// Widths follow from the coordinate width. The pipeline control group
// travels between the stage controller and the datapath as one struct.
// ============================================================================
package sch_pkg;

  // Coordinate and derived widths
  localparam int COORD_WIDTH = 16;
  localparam int CW   = COORD_WIDTH;
  localparam int RADW = CW - 1;        // radius field
  localparam int DW   = CW + 1;        // coordinate difference, signed
  localparam int PW   = 2 * DW;        // product of two differences, signed
  localparam int DOTW = 2 * DW + 2;    // three-term dot product, signed
  localparam int LENW = 2 * CW + 2;    // sum of three squares, unsigned
  localparam int R2W  = 2 * CW;        // squared radius sum
  localparam int CMW  = 2 * CW + 1;    // cross product component magnitude
  localparam int RPW  = 2 * CW + 1;    // partial product of r2 * len2
  localparam int SQW  = 4 * CW + 2;    // squared cross component
  localparam int X2W  = 4 * CW + 4;    // squared cross product length
  localparam int RLW  = 4 * CW + 2;    // r2 * len2

  // Pipeline depth
  localparam int NSTG = 8;

  // Stage control group
  typedef struct packed {
    logic [NSTG-1:0] en;
    logic [NSTG-1:0] vld;
    logic            in_ready;
  } pipe_ctl_t;

  // Signed product of two coordinate differences
  function automatic logic signed [PW-1:0] smul(logic signed [DW-1:0] a,
                                                logic signed [DW-1:0] b);
    logic signed [PW-1:0] ae;
    logic signed [PW-1:0] be;
    ae = PW'(a);
    be = PW'(b);
    return ae * be;
  endfunction

endpackage

### design/sch_if.sv
// ============================================================================
// sch_if: valid/ready channels of the sphere/capsule hit test
// One interface for the query beat and one for the result beat.
// ============================================================================
interface sch_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [sch_pkg::CW-1:0]          sphere_x;
  logic signed [sch_pkg::CW-1:0]          sphere_y;
  logic signed [sch_pkg::CW-1:0]          sphere_z;
  logic        [sch_pkg::RADW-1:0]        sphere_radius;
  logic signed [sch_pkg::CW-1:0]          axis_start_x;
  logic signed [sch_pkg::CW-1:0]          axis_start_y;
  logic signed [sch_pkg::CW-1:0]          axis_start_z;
  logic signed [sch_pkg::CW-1:0]          axis_end_x;
  logic signed [sch_pkg::CW-1:0]          axis_end_y;
  logic signed [sch_pkg::CW-1:0]          axis_end_z;
  logic        [sch_pkg::RADW-1:0]        capsule_radius;

  modport source (
    output valid, sphere_x, sphere_y, sphere_z, sphere_radius,
           axis_start_x, axis_start_y, axis_start_z,
           axis_end_x, axis_end_y, axis_end_z, capsule_radius,
    input  ready
  );
  modport sink (
    input  valid, sphere_x, sphere_y, sphere_z, sphere_radius,
           axis_start_x, axis_start_y, axis_start_z,
           axis_end_x, axis_end_y, axis_end_z, capsule_radius,
    output ready
  );
endinterface

interface sch_out_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

### design/sphere_capsule_hit_test.sv
// ============================================================================
// sphere_capsule_hit_test: exact sphere against capsule overlap test
// Eight-stage pipeline; strict overlap of a sphere and a segment capsule.
// ============================================================================
// Usage:
//   in_ch carries one query per beat: sphere centre and radius, the two
//   axis end points and the capsule radius. out_ch returns one beat per
//   query with hit = 1 when the distance from the centre to the nearest
//   axis point is strictly below the radius sum. Results keep query order.
//   An accepted query is registered in stages 0 to 7 in turn; out_ch.valid
//   comes from the stage 7 valid bit and out_ch.hit from its register.
//   Throughput is one query per cycle while out_ch.ready stays high: every
//   multiply is at most a 17x17 partial product with a register after it,
//   so the eight stages each take a beat per cycle unless stalled. The
//   interior distance uses |D x W|^2 < (r1+r2)^2 * |D|^2.
//   A zero-length axis or a projection at or before the first end point
//   tests against that end point; one at or past the second, against it.
//   Reset (synchronous, active low) clears the stage valid bits only;
//   no result is pending afterwards.
//   When out_ch.ready is low the result stays on out_ch; upstream stages
//   keep accepting until every stage holds a beat, then in_ch.ready drops.
// ============================================================================
module sphere_capsule_hit_test (
  input  logic      clk,
  input  logic      rst_n,
  sch_in_if.sink    in_ch,
  sch_out_if.source out_ch
);

  localparam int CW   = sch_pkg::CW;
  localparam int DW   = sch_pkg::DW;
  localparam int PW   = sch_pkg::PW;
  localparam int DOTW = sch_pkg::DOTW;
  localparam int LENW = sch_pkg::LENW;
  localparam int R2W  = sch_pkg::R2W;
  localparam int CMW  = sch_pkg::CMW;
  localparam int RPW  = sch_pkg::RPW;
  localparam int SQW  = sch_pkg::SQW;
  localparam int X2W  = sch_pkg::X2W;
  localparam int RLW  = sch_pkg::RLW;
  localparam int NSTG = sch_pkg::NSTG;

  typedef struct packed {
    logic sel_s;
    logic sel_e;
    logic hit_s;
    logic hit_e;
  } case_flags_t;

  sch_pkg::pipe_ctl_t ctl;

  sch_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .ctl       (ctl)
  );

  assign in_ch.ready  = ctl.in_ready;
  assign out_ch.valid = ctl.vld[NSTG-1];

  // --------------------------------------------------------------------------
  // Stage 0: axis and offset vectors, radius sum
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] p_c [3];
  logic signed [CW-1:0] s_c [3];
  logic signed [CW-1:0] e_c [3];
  logic signed [DW-1:0] d_r [3];
  logic signed [DW-1:0] w_r [3];
  logic signed [DW-1:0] v_r [3];
  logic signed [DW-1:0] d_nxt [3];
  logic signed [DW-1:0] w_nxt [3];
  logic signed [DW-1:0] v_nxt [3];
  logic [CW-1:0]        rsum_r;
  logic [CW-1:0]        rsum_nxt;

  assign p_c[0] = in_ch.sphere_x;
  assign p_c[1] = in_ch.sphere_y;
  assign p_c[2] = in_ch.sphere_z;
  assign s_c[0] = in_ch.axis_start_x;
  assign s_c[1] = in_ch.axis_start_y;
  assign s_c[2] = in_ch.axis_start_z;
  assign e_c[0] = in_ch.axis_end_x;
  assign e_c[1] = in_ch.axis_end_y;
  assign e_c[2] = in_ch.axis_end_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d_nxt[k] = DW'(e_c[k]) - DW'(s_c[k]);
      w_nxt[k] = DW'(p_c[k]) - DW'(s_c[k]);
      v_nxt[k] = DW'(p_c[k]) - DW'(e_c[k]);
    end
    rsum_nxt = CW'(in_ch.sphere_radius) + CW'(in_ch.capsule_radius);
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      d_r    <= d_nxt;
      w_r    <= w_nxt;
      v_r    <= v_nxt;
      rsum_r <= rsum_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: all component products
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] tp_r [3];
  logic signed [PW-1:0] lp_r [3];
  logic signed [PW-1:0] wp_r [3];
  logic signed [PW-1:0] vp_r [3];
  logic signed [PW-1:0] xp_r [6];
  logic signed [PW-1:0] tp_nxt [3];
  logic signed [PW-1:0] lp_nxt [3];
  logic signed [PW-1:0] wp_nxt [3];
  logic signed [PW-1:0] vp_nxt [3];
  logic signed [PW-1:0] xp_nxt [6];
  logic [R2W-1:0]       r2_r;
  logic [R2W-1:0]       r2_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tp_nxt[k] = sch_pkg::smul(d_r[k], w_r[k]);
      lp_nxt[k] = sch_pkg::smul(d_r[k], d_r[k]);
      wp_nxt[k] = sch_pkg::smul(w_r[k], w_r[k]);
      vp_nxt[k] = sch_pkg::smul(v_r[k], v_r[k]);
    end
    // cross product terms of D x W
    xp_nxt[0] = sch_pkg::smul(d_r[1], w_r[2]);
    xp_nxt[1] = sch_pkg::smul(d_r[2], w_r[1]);
    xp_nxt[2] = sch_pkg::smul(d_r[2], w_r[0]);
    xp_nxt[3] = sch_pkg::smul(d_r[0], w_r[2]);
    xp_nxt[4] = sch_pkg::smul(d_r[0], w_r[1]);
    xp_nxt[5] = sch_pkg::smul(d_r[1], w_r[0]);
    r2_nxt    = R2W'(rsum_r) * R2W'(rsum_r);
  end

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      tp_r <= tp_nxt;
      lp_r <= lp_nxt;
      wp_r <= wp_nxt;
      vp_r <= vp_nxt;
      xp_r <= xp_nxt;
      r2_r <= r2_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: dot products and cross product components
  // --------------------------------------------------------------------------
  logic signed [DOTW-1:0] t_r;
  logic signed [DOTW-1:0] t_nxt;
  logic signed [DOTW-1:0] lsum;
  logic signed [DOTW-1:0] wsum;
  logic signed [DOTW-1:0] vsum;
  logic [LENW-1:0]        len2_r;
  logic [LENW-1:0]        ww_r;
  logic [LENW-1:0]        vv_r;
  logic [LENW-1:0]        len2_nxt;
  logic [LENW-1:0]        ww_nxt;
  logic [LENW-1:0]        vv_nxt;
  logic signed [PW-1:0]   c_r [3];
  logic signed [PW-1:0]   c_nxt [3];
  logic [R2W-1:0]         r2b_r;

  always_comb begin
    t_nxt    = DOTW'(tp_r[0]) + DOTW'(tp_r[1]) + DOTW'(tp_r[2]);
    lsum     = DOTW'(lp_r[0]) + DOTW'(lp_r[1]) + DOTW'(lp_r[2]);
    wsum     = DOTW'(wp_r[0]) + DOTW'(wp_r[1]) + DOTW'(wp_r[2]);
    vsum     = DOTW'(vp_r[0]) + DOTW'(vp_r[1]) + DOTW'(vp_r[2]);
    len2_nxt = lsum[LENW-1:0];
    ww_nxt   = wsum[LENW-1:0];
    vv_nxt   = vsum[LENW-1:0];
    c_nxt[0] = xp_r[0] - xp_r[1];
    c_nxt[1] = xp_r[2] - xp_r[3];
    c_nxt[2] = xp_r[4] - xp_r[5];
  end

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      t_r    <= t_nxt;
      len2_r <= len2_nxt;
      ww_r   <= ww_nxt;
      vv_r   <= vv_nxt;
      c_r    <= c_nxt;
      r2b_r  <= r2_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: pick the nearest-point case, end point tests, magnitudes,
  // partial products of r2 * len2
  // --------------------------------------------------------------------------
  case_flags_t          flg3_r;
  case_flags_t          flg3_nxt;
  logic                 t_pos;
  logic signed [PW-1:0] c_neg [3];
  logic [CMW-1:0]       cmag_r [3];
  logic [CMW-1:0]       cmag_nxt [3];
  logic [RPW-1:0]       rp_r [4];
  logic [RPW-1:0]       rp_nxt [4];

  always_comb begin
    t_pos          = !t_r[DOTW-1] && (t_r != '0);
    flg3_nxt.sel_s = (len2_r == '0) || !t_pos;
    // t is positive and below 2^LENW here, so the low bits compare exactly
    flg3_nxt.sel_e = !flg3_nxt.sel_s && (t_r[LENW-1:0] >= len2_r);
    flg3_nxt.hit_s = ww_r < LENW'(r2b_r);
    flg3_nxt.hit_e = vv_r < LENW'(r2b_r);
    for (int k = 0; k < 3; k++) begin
      c_neg[k]    = -c_r[k];
      cmag_nxt[k] = c_r[k][PW-1] ? c_neg[k][CMW-1:0] : c_r[k][CMW-1:0];
    end
    rp_nxt[0] = RPW'(r2b_r[CW-1:0])   * RPW'(len2_r[CW:0]);
    rp_nxt[1] = RPW'(r2b_r[CW-1:0])   * RPW'(len2_r[LENW-1:CW+1]);
    rp_nxt[2] = RPW'(r2b_r[R2W-1:CW]) * RPW'(len2_r[CW:0]);
    rp_nxt[3] = RPW'(r2b_r[R2W-1:CW]) * RPW'(len2_r[LENW-1:CW+1]);
  end

  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      flg3_r <= flg3_nxt;
      cmag_r <= cmag_nxt;
      rp_r   <= rp_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: square partials of each cross component, sum r2 * len2
  // --------------------------------------------------------------------------
  case_flags_t      flg4_r;
  logic [2*CW-1:0]  hh_r [3];
  logic [2*CW:0]    hl_r [3];
  logic [2*CW+1:0]  ll_r [3];
  logic [2*CW-1:0]  hh_nxt [3];
  logic [2*CW:0]    hl_nxt [3];
  logic [2*CW+1:0]  ll_nxt [3];
  logic [RLW-1:0]   rl4_r;
  logic [RLW-1:0]   rl4_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hh_nxt[k] = (2*CW)'(cmag_r[k][CMW-1:CW+1])
                * (2*CW)'(cmag_r[k][CMW-1:CW+1]);
      hl_nxt[k] = (2*CW+1)'(cmag_r[k][CMW-1:CW+1])
                * (2*CW+1)'(cmag_r[k][CW:0]);
      ll_nxt[k] = (2*CW+2)'(cmag_r[k][CW:0])
                * (2*CW+2)'(cmag_r[k][CW:0]);
    end
    rl4_nxt = RLW'(rp_r[0])
            + (RLW'(rp_r[1]) << (CW + 1))
            + (RLW'(rp_r[2]) << CW)
            + (RLW'(rp_r[3]) << (2 * CW + 1));
  end

  always_ff @(posedge clk) begin
    if (ctl.en[4]) begin
      flg4_r <= flg3_r;
      hh_r   <= hh_nxt;
      hl_r   <= hl_nxt;
      ll_r   <= ll_nxt;
      rl4_r  <= rl4_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: combine square partials
  // --------------------------------------------------------------------------
  case_flags_t    flg5_r;
  logic [SQW-1:0] csq_r [3];
  logic [SQW-1:0] csq_nxt [3];
  logic [RLW-1:0] rl5_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      csq_nxt[k] = (SQW'(hh_r[k]) << (2 * CW + 2))
                 + (SQW'(hl_r[k]) << (CW + 2))
                 + SQW'(ll_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[5]) begin
      flg5_r <= flg4_r;
      csq_r  <= csq_nxt;
      rl5_r  <= rl4_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: squared length of D x W
  // --------------------------------------------------------------------------
  case_flags_t    flg6_r;
  logic [X2W-1:0] x2_r;
  logic [X2W-1:0] x2_nxt;
  logic [RLW-1:0] rl6_r;

  assign x2_nxt = X2W'(csq_r[0]) + X2W'(csq_r[1]) + X2W'(csq_r[2]);

  always_ff @(posedge clk) begin
    if (ctl.en[6]) begin
      flg6_r <= flg5_r;
      x2_r   <= x2_nxt;
      rl6_r  <= rl5_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: output register, select the result of the chosen case
  // --------------------------------------------------------------------------
  logic hit_r;
  logic hit_nxt;

  always_comb begin
    priority if (flg6_r.sel_s) begin
      hit_nxt = flg6_r.hit_s;
    end else if (flg6_r.sel_e) begin
      hit_nxt = flg6_r.hit_e;
    end else begin
      hit_nxt = x2_r < X2W'(rl6_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[NSTG-1]) begin
      hit_r <= hit_nxt;
    end
  end

  assign out_ch.hit = hit_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> ctl.vld[0])
    else $error("accepted beat did not enter the first stage");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (&ctl.vld && !out_ch.ready) |-> !in_ch.ready)
    else $error("input ready while every stage holds a stalled beat");

  a_zero_axis_dot: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.vld[2] && len2_r == '0) |-> (t_r == '0))
    else $error("zero-length axis with nonzero projection");

endmodule

### design/sch_pipe_ctrl.sv
// ============================================================================
// sch_pipe_ctrl: stage valid tracking and per-stage load enables
// A stage loads when it is empty or its successor loads, so bubbles
// collapse and a stalled result never blocks beats upstream of a bubble.
// ============================================================================
module sch_pipe_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               out_ready,
  output sch_pkg::pipe_ctl_t ctl
);

  logic [sch_pkg::NSTG:0]   rdy;
  logic [sch_pkg::NSTG-1:0] vld_r;
  logic [sch_pkg::NSTG-1:0] vld_nxt;

  // Propagate ready from the output back to the input
  always_comb begin
    rdy[sch_pkg::NSTG] = out_ready;
    for (int k = sch_pkg::NSTG - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  // Advance valid bits on each enabled stage
  always_comb begin
    vld_nxt[0] = rdy[0] ? in_valid : vld_r[0];
    for (int k = 1; k < sch_pkg::NSTG; k++) begin
      vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign ctl.en       = rdy[sch_pkg::NSTG-1:0];
  assign ctl.vld      = vld_r;
  assign ctl.in_ready = rdy[0];

endmodule

### test/sphere_capsule_hit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_capsule_hit_checker: result predictor and scoreboard
// Watches the query and result channels of the hit test. For every accepted
// query beat it computes the overlap flag exactly in wide integers. Each
// accepted result beat is compared with the oldest pending flag.
// ----------------------------------------------------------------------------
module sphere_capsule_hit_checker (
  input  logic        clk,
  input  logic        rst_n,
  sch_in_if           in_ch,
  sch_out_if          out_ch,
  output int unsigned error_count,
  output int unsigned pending_count
);

  localparam int CW   = sch_pkg::CW;
  localparam int RADW = sch_pkg::RADW;

  logic        expected_hits [$];
  logic        expected_hit;
  int unsigned mismatches = 0;
  int unsigned waiting    = 0;

  assign error_count   = mismatches;
  assign pending_count = waiting;

  // Exact overlap flag of one query. Nearest axis point is the first end
  // point for a zero-length axis or a projection at or before it, the second
  // end point for a projection at or past it, and the interior point
  // otherwise (compared on values scaled by the squared axis length).
  function automatic logic overlap_of(
    input logic signed [CW-1:0] px, py, pz,
    input logic        [RADW-1:0] r_sphere,
    input logic signed [CW-1:0] sx, sy, sz,
    input logic signed [CW-1:0] ex, ey, ez,
    input logic        [RADW-1:0] r_capsule
  );
    logic signed [127:0] p [3];
    logic signed [127:0] s [3];
    logic signed [127:0] e [3];
    logic signed [127:0] d [3];
    logic signed [127:0] w [3];
    logic signed [127:0] v [3];
    logic signed [127:0] proj, len2, rsum, rsum2, ww, vv;
    p[0] = px;  p[1] = py;  p[2] = pz;
    s[0] = sx;  s[1] = sy;  s[2] = sz;
    e[0] = ex;  e[1] = ey;  e[2] = ez;
    rsum = 128'(r_sphere) + 128'(r_capsule);
    proj = 0;
    len2 = 0;
    ww   = 0;
    vv   = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = e[i] - s[i];
      w[i] = p[i] - s[i];
      v[i] = p[i] - e[i];
      proj += d[i] * w[i];
      len2 += d[i] * d[i];
      ww   += w[i] * w[i];
      vv   += v[i] * v[i];
    end
    rsum2 = rsum * rsum;
    if (len2 == 0 || proj <= 0) begin
      return ww < rsum2;
    end else if (proj >= len2) begin
      return vv < rsum2;
    end
    return (ww * len2 - proj * proj) < (rsum2 * len2);
  endfunction

  // Record query beats, retire result beats in order
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_hits = {expected_hits, overlap_of(
          in_ch.sphere_x, in_ch.sphere_y, in_ch.sphere_z, in_ch.sphere_radius,
          in_ch.axis_start_x, in_ch.axis_start_y, in_ch.axis_start_z,
          in_ch.axis_end_x, in_ch.axis_end_y, in_ch.axis_end_z,
          in_ch.capsule_radius)};
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_hits.size() == 0) begin
          mismatches++;
          $error("hit: result beat with no query pending, actual %0b", out_ch.hit);
        end else begin
          expected_hit = expected_hits.pop_front();
          if (out_ch.hit !== expected_hit) begin
            mismatches++;
            $error("hit: expected %0b, actual %0b", expected_hit, out_ch.hit);
          end
        end
      end
    end
    waiting = expected_hits.size();
  end

endmodule

### test/sphere_capsule_hit_test_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_capsule_hit_test_tb: testbench of the sphere/capsule hit test
// Drives directed corner queries (zero-length axis, projection at either
// end point, touching radii, coordinate extremes) and then a random mix of
// full-range, near-boundary and clustered queries, with random idle gaps on
// both channels. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module sphere_capsule_hit_test_tb;

  localparam int CW             = sch_pkg::CW;
  localparam int RADW           = sch_pkg::RADW;
  localparam int NSTG           = sch_pkg::NSTG;
  localparam int RANDOM_QUERIES = 1750;
  localparam int TIMEOUT_NS     = 10_000_000;
  localparam int CMAX           = (1 << (CW - 1)) - 1;
  localparam int CMIN           = -(1 << (CW - 1));
  localparam int RMAX           = (1 << RADW) - 1;

  typedef struct {
    logic signed [CW-1:0]   px, py, pz;
    logic        [RADW-1:0] r_sphere;
    logic signed [CW-1:0]   sx, sy, sz;
    logic signed [CW-1:0]   ex, ey, ez;
    logic        [RADW-1:0] r_capsule;
  } query_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        quiet = 1'b0;
  int unsigned error_count;
  int unsigned pending_count;

  sch_in_if  in_ch ();
  sch_out_if out_ch ();

  sphere_capsule_hit_test i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sphere_capsule_hit_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  always #5 clk = ~clk;

  // Idle length: mostly none, some short, a few long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic query_t mk_query(int px, int py, int pz, int rs,
                                      int sx, int sy, int sz,
                                      int ex, int ey, int ez, int rc);
    query_t q;
    q.px = CW'(px);  q.py = CW'(py);  q.pz = CW'(pz);
    q.sx = CW'(sx);  q.sy = CW'(sy);  q.sz = CW'(sz);
    q.ex = CW'(ex);  q.ey = CW'(ey);  q.ez = CW'(ez);
    q.r_sphere  = RADW'(rs);
    q.r_capsule = RADW'(rc);
    return q;
  endfunction

  function automatic int pick_coord();
    case ($urandom_range(0, 6))
      0: return CMIN;
      1: return CMIN + 1;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return CMAX - 1;
      default: return CMAX;
    endcase
  endfunction

  function automatic int pick_radius();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 1;
      2: return RMAX - 1;
      default: return RMAX;
    endcase
  endfunction

  // Random query: full range, clusters, axis-aligned near-touching,
  // zero-length axis and extreme values
  function automatic query_t rand_query();
    int unsigned sel;
    int p [3];
    int s [3];
    int e [3];
    int base [3];
    int rs, rc, ax, oth, off, rsum;
    sel = $urandom_range(0, 99);
    for (int i = 0; i < 3; i++) begin
      base[i] = int'($urandom_range(0, 60000)) - 30000;
    end
    if (sel < 25) begin
      for (int i = 0; i < 3; i++) begin
        p[i] = $urandom;
        s[i] = $urandom;
        e[i] = $urandom;
      end
      rs = $urandom;
      rc = $urandom;
    end else if (sel < 55) begin
      for (int i = 0; i < 3; i++) begin
        p[i] = base[i] + int'($urandom_range(0, 80)) - 40;
        s[i] = base[i] + int'($urandom_range(0, 80)) - 40;
        e[i] = base[i] + int'($urandom_range(0, 80)) - 40;
      end
      rs = $urandom_range(0, 40);
      rc = $urandom_range(0, 40);
    end else if (sel < 75) begin
      // Axis along one dimension, sphere offset across it by off
      ax  = $urandom_range(0, 2);
      oth = (ax + 1 + $urandom_range(0, 1)) % 3;
      off = $urandom_range(0, 30);
      for (int i = 0; i < 3; i++) begin
        s[i] = base[i];
        e[i] = base[i];
        p[i] = base[i];
      end
      e[ax] += int'($urandom_range(0, 60)) - 30;
      p[ax] += int'($urandom_range(0, 80)) - 40;
      p[oth] += ($urandom_range(0, 1) != 0) ? off : -off;
      rsum = off + int'($urandom_range(0, 2)) - 1;
      if (rsum < 0) rsum = 0;
      rs = $urandom_range(0, rsum);
      rc = rsum - rs;
    end else if (sel < 85) begin
      for (int i = 0; i < 3; i++) begin
        s[i] = base[i];
        e[i] = base[i];
        p[i] = base[i] + int'($urandom_range(0, 40)) - 20;
      end
      rs = $urandom_range(0, 30);
      rc = $urandom_range(0, 30);
    end else begin
      for (int i = 0; i < 3; i++) begin
        p[i] = pick_coord();
        s[i] = pick_coord();
        e[i] = pick_coord();
      end
      rs = pick_radius();
      rc = pick_radius();
    end
    return mk_query(p[0], p[1], p[2], rs, s[0], s[1], s[2], e[0], e[1], e[2], rc);
  endfunction

  // Present one query beat and hold it until accepted
  task automatic send_query(input query_t q);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.sphere_x       <= q.px;
    in_ch.sphere_y       <= q.py;
    in_ch.sphere_z       <= q.pz;
    in_ch.sphere_radius  <= q.r_sphere;
    in_ch.axis_start_x   <= q.sx;
    in_ch.axis_start_y   <= q.sy;
    in_ch.axis_start_z   <= q.sz;
    in_ch.axis_end_x     <= q.ex;
    in_ch.axis_end_y     <= q.ey;
    in_ch.axis_end_z     <= q.ez;
    in_ch.capsule_radius <= q.r_capsule;
    @(negedge clk);
    while (in_ch.ready !== 1'b1) @(negedge clk);
    @(posedge clk);
  endtask

  // Drop valid and hold until every pending result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Result side: random stalls
  initial begin
    int unsigned gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      gap = idle_len();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Stimulus and verdict
  initial begin
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.sphere_x       <= '0;
    in_ch.sphere_y       <= '0;
    in_ch.sphere_z       <= '0;
    in_ch.sphere_radius  <= '0;
    in_ch.axis_start_x   <= '0;
    in_ch.axis_start_y   <= '0;
    in_ch.axis_start_z   <= '0;
    in_ch.axis_end_x     <= '0;
    in_ch.axis_end_y     <= '0;
    in_ch.axis_end_z     <= '0;
    in_ch.capsule_radius <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Zero-length axis: sphere against sphere, touching and overlapping
    send_query(mk_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_query(mk_query(0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0));
    send_query(mk_query(103, 4, 0, 2, 100, 0, 0, 100, 0, 0, 3));
    send_query(mk_query(103, 4, 0, 2, 100, 0, 0, 100, 0, 0, 4));
    // Projection exactly at the first end point
    send_query(mk_query(0, 5, 0, 2, 0, 0, 0, 10, 0, 0, 3));
    send_query(mk_query(0, 5, 0, 3, 0, 0, 0, 10, 0, 0, 3));
    // Projection before the first end point
    send_query(mk_query(-3, 4, 0, 5, 0, 0, 0, 10, 0, 0, 0));
    send_query(mk_query(-3, 4, 0, 5, 0, 0, 0, 10, 0, 0, 1));
    // Projection exactly at the second end point
    send_query(mk_query(10, 7, 0, 3, 0, 0, 0, 10, 0, 0, 4));
    send_query(mk_query(10, 7, 0, 4, 0, 0, 0, 10, 0, 0, 4));
    // Projection past the second end point
    send_query(mk_query(13, 0, 4, 0, 0, 0, 0, 10, 0, 0, 5));
    send_query(mk_query(13, 0, 4, 1, 0, 0, 0, 10, 0, 0, 5));
    // Interior: touching and overlapping, axis-aligned and diagonal
    send_query(mk_query(5, 3, 0, 1, 0, 0, 0, 10, 0, 0, 2));
    send_query(mk_query(5, 3, 0, 2, 0, 0, 0, 10, 0, 0, 2));
    send_query(mk_query(0, 4, 0, 1, 0, 0, 0, 4, 4, 0, 1));
    send_query(mk_query(0, 4, 0, 1, 0, 0, 0, 4, 4, 0, 2));
    send_query(mk_query(0, 0, 7, 3, 0, -5, 0, 0, 5, 14, 4));
    // Coordinate and radius extremes
    send_query(mk_query(CMIN, CMIN, CMIN, RMAX, CMIN, CMIN, CMIN,
                        CMAX, CMAX, CMAX, RMAX));
    send_query(mk_query(CMAX, CMAX, CMAX, 0, CMIN, CMIN, CMIN,
                        CMIN, CMIN, CMIN, 0));
    send_query(mk_query(CMAX, CMAX, CMAX, RMAX, CMIN, CMIN, CMIN,
                        CMIN, CMIN, CMIN, RMAX));
    send_query(mk_query(CMAX, CMIN, CMAX, RMAX, CMIN, CMAX, CMIN,
                        CMAX, CMIN, CMAX, RMAX));
    send_query(mk_query(0, CMAX, CMIN, RMAX, CMIN, 0, CMAX,
                        CMAX, 0, CMIN, RMAX));
    send_query(mk_query(-1, 1, -1, 1, 1, -1, 1, -1, 1, -1, 1));
    drain_results();

    // Random queries, with a quiet stretch and two full drains
    for (int n = 0; n < RANDOM_QUERIES; n++) begin
      if (n == 600 || n == 1300) drain_results();
      quiet = (n >= 900 && n < 1100);
      send_query(rand_query());
    end
    quiet = 1'b0;

    drain_results();
    repeat (2 * NSTG) @(posedge clk);
    if (pending_count != 0) begin
      $error("hit: %0d results never arrived", pending_count);
    end
    if (error_count == 0 && pending_count == 0) begin
      $display("sphere_capsule_hit_test_tb passed");
    end else begin
      $display("sphere_capsule_hit_test_tb failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("sphere_capsule_hit_test_tb failed");
    $finish;
  end

endmodule

### files.f
design/sch_pkg.sv
design/sch_if.sv
design/sch_pipe_ctrl.sv
design/sphere_capsule_hit_test.sv
test/sphere_capsule_hit_checker.sv
test/sphere_capsule_hit_test_tb.sv
